/* hw/rtl/stl_pkg.sv */
// shared types, constants and token helpers for the source token lexer
package stl_pkg;

    localparam int NAME_BYTES    = 8;
    localparam int MANTISSA_BITS = 48;
    localparam int NAME_W        = NAME_BYTES * 8;
    localparam int QUEUE_DEPTH   = 3;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int KEYWORDS      = 22;

    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;

    // token kinds
    localparam logic [5:0] KIND_EOF     = 6'd0;
    localparam logic [5:0] KIND_IDENT   = 6'd1;
    localparam logic [5:0] KIND_NUMBER  = 6'd2;
    localparam logic [5:0] KIND_ERROR   = 6'd3;
    localparam logic [5:0] KIND_KW_BASE = 6'd4;
    localparam logic [5:0] KIND_EQ_EQ   = 6'd26;
    localparam logic [5:0] KIND_NE      = 6'd28;
    localparam logic [5:0] KIND_GE      = 6'd30;
    localparam logic [5:0] KIND_LE      = 6'd32;
    localparam logic [5:0] KIND_PLUS    = 6'd34;
    localparam logic [5:0] KIND_MINUS   = 6'd35;
    localparam logic [5:0] KIND_STAR    = 6'd36;
    localparam logic [5:0] KIND_CHAR    = 6'd37;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    // keyword text packed first character in the low byte
    localparam logic [63:0] KW_TEXT [KEYWORDS] = '{
        64'h666564,         64'h6E7265747865,   64'h6669,           64'h6E656874,
        64'h65736C65,       64'h726F66,         64'h6E69,           64'h7972616E6962,
        64'h7972616E75,     64'h7961727261,     64'h726176,         64'h746375727473,
        64'h656C62756F64,   64'h64696F76,       64'h6E7275746572,   64'h77656E,
        64'h3169,           64'h3869,           64'h363169,         64'h323369,
        64'h343669,         64'h38323169
    };
    localparam logic [7:0] KW_LEN [KEYWORDS] = '{
        8'd3, 8'd6, 8'd2, 8'd4, 8'd4, 8'd3, 8'd2, 8'd6, 8'd5, 8'd5, 8'd3,
        8'd6, 8'd6, 8'd4, 8'd6, 8'd3, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd4
    };

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_NUMBER  = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_OP      = 3'd4
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
    } item_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  char_code;
        logic [63:0] name_chars;
        logic [7:0]  name_length;
        logic [47:0] mantissa;
        logic [7:0]  frac_digits;
        logic        last;
    } res_t;

    // what one step hands to the result queue
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } step_t;

    function automatic res_t tok_plain(input logic [5:0] kind, input logic [7:0] code);
        res_t t;
        t = '0;
        t.kind      = kind;
        t.char_code = code;
        return t;
    endfunction

    function automatic res_t tok_number(input logic [MANTISSA_BITS-1:0] value,
                                        input logic [7:0] frac);
        res_t        t;
        logic [63:0] wide;
        t    = '0;
        wide = 64'(value);
        t.kind        = KIND_NUMBER;
        t.mantissa    = wide[47:0];
        t.frac_digits = frac;
        return t;
    endfunction

    // identifier or keyword, first keyword in list order wins
    function automatic res_t tok_name(input logic [NAME_W-1:0] name, input logic [7:0] len);
        res_t        t;
        logic [63:0] wide;
        t    = '0;
        wide = 64'(name);
        t.kind        = KIND_IDENT;
        t.name_chars  = wide;
        t.name_length = len;
        for (int k = KEYWORDS - 1; k >= 0; k--) begin
            if (len == KW_LEN[k] && wide == KW_TEXT[k]) begin
                t = '0;
                t.kind = 6'(KIND_KW_BASE + 6'(k));
            end
        end
        return t;
    endfunction

endpackage

/* hw/rtl/stl_core.sv */
// lexer state registers and the single-step token logic
module stl_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  stl_pkg::item_t      item,
    output stl_pkg::step_t      step
);

    stl_pkg::mode_t                     mode_reg, mode_next, start_mode;
    logic [7:0]                         pending_op_reg, pending_op_next;
    logic [stl_pkg::NAME_W-1:0]         name_buf_reg, name_buf_next;
    logic [7:0]                         name_count_reg, name_count_next;
    logic [stl_pkg::MANTISSA_BITS-1:0]  digit_reg, digit_next;
    logic [7:0]                         frac_reg, frac_next;
    logic                               point_reg, point_next;
    logic                               ended_reg;

    logic [7:0] c;
    logic       is_space, is_alpha, is_digit, is_point, is_opchar;
    logic [3:0] d;
    logic [stl_pkg::MANTISSA_BITS+3:0] prod_ext;
    logic       fits;
    logic [5:0] op_base;

    logic          e0_v, e1_v;
    stl_pkg::res_t e0, e1, t0, t1;

    assign c         = item.ch;
    assign d         = c[3:0];
    assign is_space  = (c == stl_pkg::CH_SPACE) || (c >= stl_pkg::CH_TAB && c <= stl_pkg::CH_CR);
    assign is_alpha  = (c >= stl_pkg::CH_UP_A && c <= stl_pkg::CH_UP_Z)
                    || (c >= stl_pkg::CH_LO_A && c <= stl_pkg::CH_LO_Z);
    assign is_digit  = (c >= stl_pkg::CH_ZERO && c <= stl_pkg::CH_NINE);
    assign is_point  = (c == stl_pkg::CH_POINT);
    assign is_opchar = (c == stl_pkg::CH_EQ) || (c == stl_pkg::CH_BANG)
                    || (c == stl_pkg::CH_GT) || (c == stl_pkg::CH_LT);

    // ten times the value plus the digit, by shifts
    assign prod_ext = ({4'd0, digit_reg} << 3) + ({4'd0, digit_reg} << 1)
                    + (stl_pkg::MANTISSA_BITS + 4)'(d);
    assign fits     = prod_ext <= {4'd0, stl_pkg::MANT_MAX};

    always_comb begin
        unique case (pending_op_reg)
            stl_pkg::CH_EQ:   op_base = stl_pkg::KIND_EQ_EQ;
            stl_pkg::CH_BANG: op_base = stl_pkg::KIND_NE;
            stl_pkg::CH_GT:   op_base = stl_pkg::KIND_GE;
            default:          op_base = stl_pkg::KIND_LE;
        endcase
    end

    always_comb begin
        if (is_space) begin
            start_mode = stl_pkg::MODE_IDLE;
        end else if (is_alpha) begin
            start_mode = stl_pkg::MODE_IDENT;
        end else if (is_digit || is_point) begin
            start_mode = stl_pkg::MODE_NUMBER;
        end else if (c == stl_pkg::CH_HASH) begin
            start_mode = stl_pkg::MODE_COMMENT;
        end else if (is_opchar) begin
            start_mode = stl_pkg::MODE_OP;
        end else begin
            start_mode = stl_pkg::MODE_IDLE;
        end
    end

    // next mode
    always_comb begin
        mode_next = mode_reg;
        if (ended_reg) begin
            mode_next = mode_reg;
        end else if (item.at_end) begin
            mode_next = stl_pkg::MODE_IDLE;
        end else begin
            unique case (mode_reg)
                stl_pkg::MODE_IDENT: begin
                    if (!(is_alpha || is_digit)) mode_next = start_mode;
                end
                stl_pkg::MODE_NUMBER: begin
                    if (!(is_digit || is_point)) mode_next = start_mode;
                end
                stl_pkg::MODE_COMMENT: begin
                    if (c == stl_pkg::CH_LF || c == stl_pkg::CH_CR) begin
                        mode_next = stl_pkg::MODE_IDLE;
                    end
                end
                stl_pkg::MODE_OP: begin
                    mode_next = (c == stl_pkg::CH_EQ) ? stl_pkg::MODE_IDLE : start_mode;
                end
                default: mode_next = start_mode;
            endcase
        end
    end

    // tokens and datapath
    always_comb begin
        logic do_start;
        do_start        = 1'b0;
        e0_v            = 1'b0;
        e1_v            = 1'b0;
        e0              = stl_pkg::tok_plain(stl_pkg::KIND_EOF, 8'd0);
        e1              = stl_pkg::tok_plain(stl_pkg::KIND_EOF, 8'd0);
        pending_op_next = pending_op_reg;
        name_buf_next   = name_buf_reg;
        name_count_next = name_count_reg;
        digit_next      = digit_reg;
        frac_next       = frac_reg;
        point_next      = point_reg;

        if (ended_reg) begin
            e0_v = 1'b1;
        end else if (item.at_end) begin
            // flush the open token, then eof
            e1_v = 1'b1;
            unique case (mode_reg)
                stl_pkg::MODE_IDENT: begin
                    e0_v = 1'b1;
                    e0   = stl_pkg::tok_name(name_buf_reg, name_count_reg);
                end
                stl_pkg::MODE_NUMBER: begin
                    e0_v = 1'b1;
                    e0   = stl_pkg::tok_number(digit_reg, frac_reg);
                end
                stl_pkg::MODE_OP: begin
                    e0_v = 1'b1;
                    e0   = stl_pkg::tok_plain(6'(op_base + 6'd1), 8'd0);
                end
                default: e0_v = 1'b0;
            endcase
        end else begin
            unique case (mode_reg)
                stl_pkg::MODE_IDENT: begin
                    if (is_alpha || is_digit) begin
                        for (int i = 0; i < stl_pkg::NAME_BYTES; i++) begin
                            if (name_count_reg == 8'(i)) name_buf_next[i*8 +: 8] = c;
                        end
                        if (name_count_reg != 8'hFF) name_count_next = name_count_reg + 8'd1;
                    end else begin
                        e0_v     = 1'b1;
                        e0       = stl_pkg::tok_name(name_buf_reg, name_count_reg);
                        do_start = 1'b1;
                    end
                end
                stl_pkg::MODE_NUMBER: begin
                    if (is_point) begin
                        if (point_reg) begin
                            // second point: error, number restarts here
                            e0_v       = 1'b1;
                            e0         = stl_pkg::tok_plain(stl_pkg::KIND_ERROR, 8'd0);
                            digit_next = '0;
                            frac_next  = 8'd0;
                        end
                        point_next = 1'b1;
                    end else if (is_digit) begin
                        if (point_reg) begin
                            if (fits && frac_reg != 8'hFF) begin
                                digit_next = prod_ext[stl_pkg::MANTISSA_BITS-1:0];
                                frac_next  = frac_reg + 8'd1;
                            end
                        end else begin
                            digit_next = fits ? prod_ext[stl_pkg::MANTISSA_BITS-1:0]
                                              : stl_pkg::MANT_MAX;
                        end
                    end else begin
                        e0_v     = 1'b1;
                        e0       = stl_pkg::tok_number(digit_reg, frac_reg);
                        do_start = 1'b1;
                    end
                end
                stl_pkg::MODE_COMMENT: begin
                    e0_v = 1'b0;
                end
                stl_pkg::MODE_OP: begin
                    e0_v = 1'b1;
                    if (c == stl_pkg::CH_EQ) begin
                        e0 = stl_pkg::tok_plain(op_base, 8'd0);
                    end else begin
                        e0       = stl_pkg::tok_plain(6'(op_base + 6'd1), 8'd0);
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end

        if (do_start) begin
            if (is_space) begin
                e1_v = 1'b0;
            end else if (is_alpha) begin
                name_buf_next   = stl_pkg::NAME_W'(c);
                name_count_next = 8'd1;
            end else if (is_digit || is_point) begin
                digit_next = is_digit ? stl_pkg::MANTISSA_BITS'(d) : '0;
                frac_next  = 8'd0;
                point_next = is_point;
            end else if (c == stl_pkg::CH_HASH) begin
                e1_v = 1'b0;
            end else if (is_opchar) begin
                pending_op_next = c;
            end else if (c == stl_pkg::CH_PLUS) begin
                e1_v = 1'b1;
                e1   = stl_pkg::tok_plain(stl_pkg::KIND_PLUS, 8'd0);
            end else if (c == stl_pkg::CH_MINUS) begin
                e1_v = 1'b1;
                e1   = stl_pkg::tok_plain(stl_pkg::KIND_MINUS, 8'd0);
            end else if (c == stl_pkg::CH_STAR) begin
                e1_v = 1'b1;
                e1   = stl_pkg::tok_plain(stl_pkg::KIND_STAR, 8'd0);
            end else begin
                e1_v = 1'b1;
                e1   = stl_pkg::tok_plain(stl_pkg::KIND_CHAR, c);
            end
        end
    end

    // pack the tokens in order and mark the final one
    always_comb begin
        t0 = e0_v ? e0 : e1;
        t1 = e1;
        step.count  = {1'b0, e0_v} + {1'b0, e1_v};
        t0.last     = (step.count == 2'd1);
        t1.last     = 1'b1;
        step.first  = t0;
        step.second = t1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= stl_pkg::MODE_IDLE;
            pending_op_reg <= 8'd0;
            name_buf_reg   <= '0;
            name_count_reg <= 8'd0;
            digit_reg      <= '0;
            frac_reg       <= 8'd0;
            point_reg      <= 1'b0;
            ended_reg      <= 1'b0;
        end else if (fire) begin
            mode_reg       <= mode_next;
            pending_op_reg <= pending_op_next;
            name_buf_reg   <= name_buf_next;
            name_count_reg <= name_count_next;
            digit_reg      <= digit_next;
            frac_reg       <= frac_next;
            point_reg      <= point_next;
            ended_reg      <= ended_reg | item.at_end;
        end
    end

    a_ended_eof_only: assert property (@(posedge aclk) disable iff (!aresetn)
        ended_reg |-> step.count == 2'd1 && step.first.kind == stl_pkg::KIND_EOF)
        else $error("step after end of input gave more than one eof");

    a_end_gives_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !ended_reg && item.at_end |=> ended_reg && mode_reg == stl_pkg::MODE_IDLE)
        else $error("end of input did not close the stream");

    a_last_marks_final: assert property (@(posedge aclk) disable iff (!aresetn)
        step.count == 2'd2 |-> !step.first.last && step.second.last)
        else $error("last flag not on the final token of a step");

endmodule

/* hw/rtl/stl_res_queue.sv */
// three-entry result queue, takes up to two tokens a cycle and gives one while m_ready is high
module stl_res_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  stl_pkg::step_t step,
    output logic           room,
    output logic           m_valid,
    input  logic           m_ready,
    output stl_pkg::res_t  m_data
);

    stl_pkg::res_t              slot_reg [stl_pkg::QUEUE_DEPTH];
    logic [stl_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next, wr_ptr_two;
    logic [stl_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [1:0]                 push_count;
    logic                       pop;

    function automatic logic [stl_pkg::PTR_W-1:0] ptr_inc(input logic [stl_pkg::PTR_W-1:0] p);
        return (p == stl_pkg::PTR_W'(stl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_count  = push ? step.count : 2'd0;
    assign pop         = m_valid && m_ready;
    assign m_valid     = (count_reg != '0);
    assign m_data      = slot_reg[rd_ptr_reg];
    // room for two more regardless of the consumer
    assign room        = count_reg <= stl_pkg::CNT_W'(stl_pkg::QUEUE_DEPTH - 2);
    assign wr_ptr_two  = ptr_inc(wr_ptr_reg);
    assign rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    assign wr_ptr_next = (push_count == 2'd2) ? ptr_inc(wr_ptr_two)
                       : (push_count == 2'd1) ? wr_ptr_two : wr_ptr_reg;
    assign count_next  = count_reg + stl_pkg::CNT_W'(push_count) - stl_pkg::CNT_W'(pop);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < stl_pkg::QUEUE_DEPTH; i++) begin
            if (push_count != 2'd0 && wr_ptr_reg == stl_pkg::PTR_W'(i)) begin
                slot_reg[i] <= step.first;
            end else if (push_count == 2'd2 && wr_ptr_two == stl_pkg::PTR_W'(i)) begin
                slot_reg[i] <= step.second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_count != 2'd0 |-> room)
        else $error("tokens pushed without room");

    a_double_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push_count == 2'd2 && !pop |=> count_reg == $past(count_reg) + 2'd2)
        else $error("double push lost a token");

    a_count_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> rd_ptr_reg == wr_ptr_reg)
        else $error("empty queue with pointers apart");

endmodule

/* hw/rtl/source_token_lexer.sv */
// top level of the streaming source token lexer
//
// usage
//   s_ channel: one beat is one source byte (ch) or an end-of-input mark (at_end)
//   m_ channel: one beat is one token; a byte gives zero, one or two tokens and
//   the final token of each byte carries last
//   path: each byte waits in the input register, then its tokens in the queue
//   throughput: one byte a cycle while m_ready is high and each byte gives at
//   most one token; a byte that gives two tokens holds the next byte back until
//   the queue can again take two; the rate is set by the single-pass lexer step
//   and the one-token-a-cycle result port behind a three-entry queue
//   reset: aresetn low at a clock edge empties the input register and the queue
//   and returns the lexer to idle with no partial token
//   stall: while m_ready is low the queue keeps its tokens; bytes are still
//   taken until the queue can no longer hold two more tokens, then s_ready drops
//   after end of input every further beat gives a single eof token
module source_token_lexer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  stl_pkg::item_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output stl_pkg::res_t  m_data
);

    // input register stage
    stl_pkg::item_t item_reg;
    logic           item_valid_reg;

    logic           room;
    logic           fire;
    stl_pkg::step_t step;

    // the step runs when a byte is held and the queue can take two tokens
    assign fire    = item_valid_reg && room;
    assign s_ready = !item_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    stl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .step    (step)
    );

    stl_res_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fire),
        .step    (step),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && !room |=> item_valid_reg && $stable(item_reg))
        else $error("held byte lost while the queue was full");

endmodule

/* verif/tb_source_token_lexer.sv */
`timescale 1ns / 100ps
// self-checking testbench for the source token lexer, directed table then random source text
module tb_source_token_lexer;
    import stl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;
    localparam int PLAIN_BYTES = 600;
    localparam int DRAIN_WAIT  = 16;

    localparam logic [7:0]  CH_VT     = 8'h0B;
    localparam logic [7:0]  CH_FF     = 8'h0C;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [63:0] VALUE_MAX = (64'd1 << MANTISSA_BITS) - 64'd1;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    item_t s_data  = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    res_t  m_data;

    source_token_lexer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // tokens the lexer still owes us, oldest first
    res_t tokens_due [$];
    int   errors = 0;
    int   cycles = 0;

    // idling percentages for the current part of the run
    int send_gap = 0;
    int recv_gap = 0;

    // ------------------------------------------------------------------
    // lexer shadow state
    // ------------------------------------------------------------------
    mode_t       lx_mode  = MODE_IDLE;
    logic [7:0]  lx_op    = '0;
    logic [63:0] lx_name  = '0;
    logic [7:0]  lx_len   = '0;
    logic [63:0] lx_value = '0;
    logic [7:0]  lx_frac  = '0;
    bit          lx_point = 1'b0;
    bit          lx_ended = 1'b0;

    // tokens produced by the byte just accepted
    res_t step_tok [2];
    int   step_n;

    function automatic string keyword_text(input int k);
        case (k)
            0:  return "def";
            1:  return "extern";
            2:  return "if";
            3:  return "then";
            4:  return "else";
            5:  return "for";
            6:  return "in";
            7:  return "binary";
            8:  return "unary";
            9:  return "array";
            10: return "var";
            11: return "struct";
            12: return "double";
            13: return "void";
            14: return "return";
            15: return "new";
            16: return "i1";
            17: return "i8";
            18: return "i16";
            19: return "i32";
            20: return "i64";
            default: return "i128";
        endcase
    endfunction

    function automatic res_t tok(input logic [5:0] kind, input logic [7:0] code,
                                 input logic [63:0] name, input logic [7:0] len,
                                 input logic [63:0] mant, input logic [7:0] frac);
        res_t t;
        t             = '0;
        t.kind        = kind;
        t.char_code   = code;
        t.name_chars  = name;
        t.name_length = len;
        t.mantissa    = mant[47:0];
        t.frac_digits = frac;
        return t;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void emit_tok(input res_t t);
        step_tok[step_n] = t;
        step_n++;
    endfunction

    // whole-name keyword match, otherwise an identifier
    function automatic void emit_name();
        string       s;
        logic [63:0] kw_bits;
        int          hit;
        hit = -1;
        for (int k = 0; k < KEYWORDS; k++) begin
            s       = keyword_text(k);
            kw_bits = '0;
            for (int i = 0; i < s.len(); i++)
                kw_bits |= 64'(s[i]) << (8 * i);
            if (hit < 0 && lx_len == s.len() && lx_name == kw_bits)
                hit = k;
        end
        if (hit >= 0)
            emit_tok(tok(6'(KIND_KW_BASE + hit), 0, 0, 0, 0, 0));
        else
            emit_tok(tok(KIND_IDENT, 0, lx_name, lx_len, 0, 0));
    endfunction

    function automatic void emit_number();
        emit_tok(tok(KIND_NUMBER, 0, 0, 0, lx_value, lx_frac));
    endfunction

    function automatic logic [5:0] op_kind();
        case (lx_op)
            CH_EQ:   return KIND_EQ_EQ;
            CH_BANG: return KIND_NE;
            CH_GT:   return KIND_GE;
            default: return KIND_LE;
        endcase
    endfunction

    function automatic void number_char(input logic [7:0] c);
        logic [63:0] d;
        bit          fits;
        if (c == CH_POINT) begin
            // second point: error, then a fresh number from here
            if (lx_point) begin
                emit_tok(tok(KIND_ERROR, 0, 0, 0, 0, 0));
                lx_value = '0;
                lx_frac  = '0;
            end
            lx_point = 1'b1;
        end else begin
            d    = 64'(c) - 64'(CH_ZERO);
            fits = lx_value <= (VALUE_MAX - d) / 64'd10;
            if (lx_point) begin
                // fraction digits that do not fit are dropped
                if (fits && lx_frac < 8'd255) begin
                    lx_value = lx_value * 64'd10 + d;
                    lx_frac++;
                end
            end else begin
                lx_value = fits ? lx_value * 64'd10 + d : VALUE_MAX;
            end
        end
    endfunction

    function automatic void start_char(input logic [7:0] c);
        lx_mode = MODE_IDLE;
        if (is_space(c)) begin
        end else if (is_alpha(c)) begin
            lx_mode = MODE_IDENT;
            lx_name = 64'(c);
            lx_len  = 8'd1;
        end else if (is_digit(c) || c == CH_POINT) begin
            lx_mode  = MODE_NUMBER;
            lx_value = '0;
            lx_frac  = '0;
            lx_point = 1'b0;
            number_char(c);
        end else if (c == CH_HASH) begin
            lx_mode = MODE_COMMENT;
        end else if (c == CH_EQ || c == CH_BANG || c == CH_GT || c == CH_LT) begin
            lx_mode = MODE_OP;
            lx_op   = c;
        end else if (c == CH_PLUS) begin
            emit_tok(tok(KIND_PLUS, 0, 0, 0, 0, 0));
        end else if (c == CH_MINUS) begin
            emit_tok(tok(KIND_MINUS, 0, 0, 0, 0, 0));
        end else if (c == CH_STAR) begin
            emit_tok(tok(KIND_STAR, 0, 0, 0, 0, 0));
        end else begin
            emit_tok(tok(KIND_CHAR, c, 0, 0, 0, 0));
        end
    endfunction

    // advance the shadow lexer by one beat, leaving its tokens in step_tok
    function automatic void lex_byte(input item_t it);
        logic [7:0] c;
        c      = it.ch;
        step_n = 0;
        if (lx_ended) begin
            emit_tok(tok(KIND_EOF, 0, 0, 0, 0, 0));
        end else if (it.at_end) begin
            case (lx_mode)
                MODE_IDENT:  emit_name();
                MODE_NUMBER: emit_number();
                MODE_OP:     emit_tok(tok(op_kind() + 6'd1, 0, 0, 0, 0, 0));
                default: ;
            endcase
            emit_tok(tok(KIND_EOF, 0, 0, 0, 0, 0));
            lx_mode  = MODE_IDLE;
            lx_ended = 1'b1;
        end else begin
            case (lx_mode)
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        // long names keep counting past the stored bytes
                        if (lx_len < NAME_BYTES)
                            lx_name |= 64'(c) << (8 * lx_len);
                        if (lx_len < 8'd255)
                            lx_len++;
                    end else begin
                        emit_name();
                        start_char(c);
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(c) || c == CH_POINT) begin
                        number_char(c);
                    end else begin
                        emit_number();
                        start_char(c);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF || c == CH_CR)
                        lx_mode = MODE_IDLE;
                end
                MODE_OP: begin
                    if (c == CH_EQ) begin
                        emit_tok(tok(op_kind(), 0, 0, 0, 0, 0));
                        lx_mode = MODE_IDLE;
                    end else begin
                        emit_tok(tok(op_kind() + 6'd1, 0, 0, 0, 0, 0));
                        start_char(c);
                    end
                end
                default: start_char(c);
            endcase
        end
        if (step_n > 0)
            step_tok[step_n - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus storage and source text generation
    // ------------------------------------------------------------------
    logic [7:0] dir_ch_q    [$];
    bit         dir_typed_q [$];
    res_t       dir_tok_q   [$];
    item_t      src_q       [$];

    task automatic add_row(input logic [7:0] c, input bit typed, input res_t t);
        dir_ch_q.push_back(c);
        dir_typed_q.push_back(typed);
        dir_tok_q.push_back(t);
    endtask

    task automatic put(input logic [7:0] c);
        item_t it;
        it.ch     = c;
        it.at_end = 1'b0;
        src_q.push_back(it);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(8'(s[i]));
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1) == 0)
            return 8'(CH_UP_A + $urandom_range(25));
        return 8'(CH_LO_A + $urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_space();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // one token's worth of plausible source text, sometimes noise
    task automatic gen_fragment();
        int    sel;
        int    n;
        string punct;
        punct = "()/,;{}[]";
        sel   = $urandom_range(99);
        if (sel < 18) begin
            put_text(keyword_text($urandom_range(KEYWORDS - 1)));
        end else if (sel < 36) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(7, 1);
            put(rand_letter());
            for (int k = 1; k < n; k++)
                put(($urandom_range(3) == 0) ? rand_digit() : rand_letter());
        end else if (sel < 56) begin
            // integer part, long enough now and then to saturate
            if ($urandom_range(9) == 0) begin
                put(CH_POINT);
            end else begin
                n = ($urandom_range(4) == 0) ? $urandom_range(22, 14) : $urandom_range(6, 1);
                for (int k = 0; k < n; k++)
                    put(rand_digit());
                if ($urandom_range(1) == 0)
                    put(CH_POINT);
            end
            n = ($urandom_range(5) == 0) ? $urandom_range(20, 10) : $urandom_range(5, 0);
            for (int k = 0; k < n; k++)
                put(rand_digit());
            // the odd second point
            if ($urandom_range(7) == 0) begin
                put(CH_POINT);
                n = $urandom_range(4, 0);
                for (int k = 0; k < n; k++)
                    put(rand_digit());
            end
        end else if (sel < 71) begin
            case ($urandom_range(10))
                0:       put_text("=");
                1:       put_text("==");
                2:       put_text("!");
                3:       put_text("!=");
                4:       put_text(">");
                5:       put_text(">=");
                6:       put_text("<");
                7:       put_text("<=");
                8:       put_text("+");
                9:       put_text("-");
                default: put_text("*");
            endcase
        end else if (sel < 77) begin
            put(CH_HASH);
            n = $urandom_range(10, 0);
            for (int k = 0; k < n; k++)
                put(($urandom_range(1) == 0) ? 8'($urandom_range(126, 32))
                                             : 8'($urandom_range(255, 128)));
            put(($urandom_range(1) == 0) ? CH_LF : CH_CR);
        end else if (sel < 85) begin
            put(8'(punct[$urandom_range(punct.len() - 1)]));
        end else if (sel < 93) begin
            n = $urandom_range(3, 1);
            for (int k = 0; k < n; k++)
                put(rand_space());
        end else begin
            put(8'($urandom_range(255)));
        end
        if ($urandom_range(1) == 0)
            put(rand_space());
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // sender and receiver swap idling rates across the run, then both go flat out
    task automatic pick_idling(input int idx, input int total);
        case ((idx * 3) / total)
            0: begin
                send_gap = 36;
                recv_gap = 68;
            end
            1: begin
                send_gap = 68;
                recv_gap = 36;
            end
            default: begin
                send_gap = 0;
                recv_gap = 0;
            end
        endcase
    endtask

    // present one beat, wait for acceptance, then queue what it should produce
    task automatic feed_item(input item_t it, input bit typed, input res_t typed_tok);
        if ($urandom_range(99) < send_gap) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_gap);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        lex_byte(it);
        // a typed row fixes the final token of its beat by hand
        if (typed && step_n > 0) begin
            step_tok[step_n - 1]      = typed_tok;
            step_tok[step_n - 1].last = 1'b1;
        end
        for (int k = 0; k < step_n; k++)
            tokens_due.push_back(step_tok[k]);
    endtask

    initial begin : stimulus
        int    total;
        int    idx;
        int    frag;
        int    special_bytes;
        int    mark;
        item_t it;

        // directed table: extremes, + - * == >= and a lone ! and <, the special cases
        add_row(8'h00,    1'b1, tok(KIND_CHAR, 8'h00, 0, 0, 0, 0));   // lowest byte
        add_row(8'hFF,    1'b1, tok(KIND_CHAR, 8'hFF, 0, 0, 0, 0));   // highest byte
        add_row(CH_SLASH, 1'b1, tok(KIND_CHAR, CH_SLASH, 0, 0, 0, 0)); // slash is plain
        add_row(CH_PLUS,  1'b1, tok(KIND_PLUS, 0, 0, 0, 0, 0));
        add_row(CH_MINUS, 1'b1, tok(KIND_MINUS, 0, 0, 0, 0, 0));
        add_row(CH_STAR,  1'b1, tok(KIND_STAR, 0, 0, 0, 0, 0));
        add_row(CH_EQ,    1'b0, '0);
        add_row(CH_EQ,    1'b1, tok(KIND_EQ_EQ, 0, 0, 0, 0, 0));
        add_row(CH_GT,    1'b0, '0);
        add_row(CH_EQ,    1'b1, tok(KIND_GE, 0, 0, 0, 0, 0));
        add_row(CH_BANG,  1'b0, '0);
        add_row("x",      1'b0, '0);                                  // lone bang, then a name
        add_row(CH_POINT, 1'b0, '0);                                  // name closed by a point
        add_row(CH_POINT, 1'b1, tok(KIND_ERROR, 0, 0, 0, 0, 0));      // second point
        add_row(CH_SPACE, 1'b1, tok(KIND_NUMBER, 0, 0, 0, 0, 0));     // lone point is zero
        add_row(CH_HASH,  1'b0, '0);
        add_row("q",      1'b0, '0);                                  // swallowed by comment
        add_row(CH_LF,    1'b0, '0);
        add_row("i",      1'b0, '0);
        add_row("f",      1'b0, '0);
        add_row(CH_LT,    1'b0, '0);                                  // keyword if, then '<'
        add_row("9",      1'b0, '0);                                  // bare '<' closed by digit
        add_row(CH_POINT, 1'b0, '0);
        add_row("5",      1'b0, '0);
        add_row(CH_CR,    1'b0, '0);

        // random source text, with one long name and one very long fraction mid-way
        frag          = 0;
        special_bytes = 0;
        while (src_q.size() - special_bytes < PLAIN_BYTES) begin
            if (frag == 40) begin
                mark = src_q.size();
                put(rand_letter());
                for (int k = 0; k < 259; k++)
                    put(($urandom_range(3) == 0) ? rand_digit() : rand_letter());
                put(CH_SPACE);
                special_bytes += src_q.size() - mark;
            end
            if (frag == 90) begin
                mark = src_q.size();
                put_text("0.");
                for (int k = 0; k < 258; k++)
                    put(CH_ZERO);
                put_text("7 ");
                special_bytes += src_q.size() - mark;
            end
            gen_fragment();
            frag++;
        end

        // close with a pending operator, then end of input and beats after it
        put(CH_GT);
        it.ch     = 8'($urandom_range(255));
        it.at_end = 1'b1;
        src_q.push_back(it);
        put(8'($urandom_range(255)));
        it.ch = 8'($urandom_range(255));
        src_q.push_back(it);

        total = dir_ch_q.size() + src_q.size();
        idx   = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_ch_q[i]) begin
            pick_idling(idx, total);
            it.ch     = dir_ch_q[i];
            it.at_end = 1'b0;
            feed_item(it, dir_typed_q[i], dir_tok_q[i]);
            idx++;
        end
        foreach (src_q[i]) begin
            pick_idling(idx, total);
            feed_item(src_q[i], 1'b0, '0);
            idx++;
        end
        s_valid <= 1'b0;

        // drain, then give the pipeline time to show any stray token
        while (tokens_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (errors == 0 && tokens_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: check each accepted beat, then pick the next ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : token_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tokens_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected token: got %h", m_data);
            end else begin
                want = tokens_due.pop_front();
                if (m_data.kind !== want.kind || m_data.char_code !== want.char_code
                    || m_data.name_chars !== want.name_chars
                    || m_data.name_length !== want.name_length
                    || m_data.mantissa !== want.mantissa
                    || m_data.frac_digits !== want.frac_digits
                    || m_data.last !== want.last) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("token mismatch: expected %h got %h", want, m_data);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_gap);
    end

    // watchdog
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
